@@ rtl/lrast_pkg.sv @@
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared constants and types for the lazy range-assign segment tree.
// ----------------------------------------------------------------------------
package lrast_pkg;

  localparam int MAX_LENGTH  = 1024;
  localparam int IDX_W       = 10;
  localparam int LEN_W       = 11;
  localparam int NODE_W      = 13;
  localparam int NODE_COUNT  = 4 * MAX_LENGTH + 1;
  localparam int VALUE_W     = 32;
  localparam int STACK_DEPTH = 24;
  localparam int SP_W        = 5;
  localparam int POS_W       = 4;

  localparam logic [0:0] ACT_ASSIGN = 1'b0;
  localparam logic [0:0] ACT_READ   = 1'b1;

  // classified request held in the queue between front and back
  typedef struct packed {
    logic                      is_read;
    logic [IDX_W-1:0]          first;
    logic [IDX_W-1:0]          last;
    logic signed [VALUE_W-1:0] value;
    logic [NODE_W-1:0]         node;
    logic [POS_W-1:0]          msb_pos;
    logic                      node_ok;
  } cmd_t;

  // one walk stack entry: node and the span it covers
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
  } frame_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/lrast_ifs.sv @@
// ----------------------------------------------------------------------------
// lrast interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrast_in_if;
  import lrast_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [0:0]                action;
  logic [IDX_W-1:0]          range_start;
  logic [IDX_W-1:0]          range_end;
  logic signed [VALUE_W-1:0] assign_value;
  logic [NODE_W-1:0]         node_index;
  modport source (output valid, action, range_start, range_end, assign_value, node_index,
                  input ready);
  modport sink (input valid, action, range_start, range_end, assign_value, node_index,
                output ready);
endinterface

interface lrast_out_if;
  import lrast_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] node_value;
  logic                      node_pending;
  logic [IDX_W-1:0]          node_low;
  logic [IDX_W-1:0]          node_high;
  modport source (output valid, node_value, node_pending, node_low, node_high,
                  input ready);
  modport sink (input valid, node_value, node_pending, node_low, node_high,
                output ready);
endinterface

@@ rtl/lrast_queue.sv @@
// ----------------------------------------------------------------------------
// lrast_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module lrast_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lrast_pkg::cmd_t   push_cmd,
  input  logic              pop,
  output lrast_pkg::cmd_t   head_cmd,
  output lrast_pkg::q_stat_t stat
);
  import lrast_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head_cmd   = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/lrast_front.sv @@
// ----------------------------------------------------------------------------
// lrast_front
// Accepts requests, drops empty assigns and precomputes read descent data.
// ----------------------------------------------------------------------------
module lrast_front (
  lrast_in_if.sink            in_chan,
  input  lrast_pkg::q_stat_t  q_stat,
  input  logic                clearing,
  output logic                push,
  output lrast_pkg::cmd_t     push_cmd
);
  import lrast_pkg::*;

  logic             take;
  logic [POS_W-1:0] pos;

  assign in_chan.ready = !q_stat.full && !clearing;
  assign take          = in_chan.valid && in_chan.ready;

  // leading one of the node index sets the descent length
  always_comb begin
    pos = '0;
    for (int b = 0; b < NODE_W; b++) begin
      if (in_chan.node_index[b]) begin
        pos = POS_W'(b);
      end
    end
  end

  // classify
  always_comb begin
    push_cmd.is_read = (in_chan.action == ACT_READ);
    push_cmd.first   = in_chan.range_start;
    push_cmd.last    = in_chan.range_end;
    push_cmd.value   = in_chan.assign_value;
    push_cmd.node    = in_chan.node_index;
    push_cmd.msb_pos = pos;
    push_cmd.node_ok = (in_chan.node_index != '0) &&
                       (in_chan.node_index < NODE_W'(NODE_COUNT));
    // an empty range changes nothing and gives no result
    push = take && ((in_chan.action == ACT_READ) ||
                    (in_chan.range_end >= in_chan.range_start));
  end

endmodule

@@ rtl/lrast_back.sv @@
// ----------------------------------------------------------------------------
// lrast_back
// Walk engine: node memory, walk stack, read descent and result register.
// ----------------------------------------------------------------------------
module lrast_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [lrast_pkg::LEN_W-1:0] cfg_wr_data,
  input  lrast_pkg::cmd_t       head_cmd,
  input  lrast_pkg::q_stat_t    q_stat,
  output logic                  pop,
  output logic                  clearing,
  lrast_out_if.source           out_chan
);
  import lrast_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EVAL   = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_WLEFT  = 4'd4;
  localparam logic [3:0] S_WRIGHT = 4'd5;
  localparam logic [3:0] S_DESC   = 4'd6;
  localparam logic [3:0] S_RDOUT  = 4'd7;

  localparam int WORD_W = VALUE_W + 1;

  logic [3:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    len_m1_r;
  logic [NODE_W-1:0]   clr_addr_r;
  cmd_t                cmd_r;
  frame_t              stack_r [STACK_DEPTH];
  logic [SP_W-1:0]     sp_r;
  frame_t              cur_r;
  logic [IDX_W-1:0]    mid_r;
  logic [VALUE_W-1:0]  push_val_r;
  logic [IDX_W-1:0]    dlo_r, dhi_r;
  logic [POS_W-1:0]    k_r;
  logic                used_r;

  logic [WORD_W-1:0]   mem [NODE_COUNT];
  logic [WORD_W-1:0]   rd_data_r;
  logic                mem_we, mem_re;
  logic [NODE_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata;

  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_pend_r;
  logic [IDX_W-1:0]    out_lo_r, out_hi_r;

  frame_t              top;
  logic                no_overlap, full_cover;
  logic [IDX_W-1:0]    top_mid, d_mid;
  logic [LEN_W-1:0]    cfg_len;
  logic [NODE_W-1:0]   left_node;

  assign clearing = (state_r == S_CLEAR);
  assign top      = stack_r[sp_r - SP_W'(1)];
  assign no_overlap = (cmd_r.last < top.lo) || (top.hi < cmd_r.first);
  assign full_cover = (top.lo >= cmd_r.first) && (top.hi <= cmd_r.last);
  assign top_mid  = IDX_W'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
  assign d_mid    = IDX_W'(({1'b0, dlo_r} + {1'b0, dhi_r}) >> 1);
  assign left_node = NODE_W'({cur_r.node, 1'b0});

  // length written is held to 1..MAX_LENGTH
  always_comb begin
    cfg_len = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      cfg_len = LEN_W'(1);
    end else if (cfg_wr_data > LEN_W'(MAX_LENGTH)) begin
      cfg_len = LEN_W'(MAX_LENGTH);
    end
  end

  // sequencer and memory port control
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_r.node;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = top.node;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (head_cmd.is_read) begin
            mem_re    = 1'b1;
            mem_raddr = head_cmd.node_ok ? head_cmd.node : '0;
            state_nxt = S_DESC;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (sp_r == '0) begin
          state_nxt = S_IDLE;
        end else if (!no_overlap && full_cover) begin
          mem_we    = 1'b1;
          mem_waddr = top.node;
          mem_wdata = {1'b1, cmd_r.value};
        end else if (!no_overlap) begin
          mem_re    = 1'b1;
          state_nxt = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        // a pending mark is cleared here; S_WLEFT and S_WRIGHT push it to both children
        if (rd_data_r[VALUE_W]) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, rd_data_r[VALUE_W-1:0]};
          state_nxt = S_WLEFT;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_WLEFT: begin
        mem_we    = 1'b1;
        mem_waddr = left_node;
        mem_wdata = {1'b1, push_val_r};
        state_nxt = S_WRIGHT;
      end
      S_WRIGHT: begin
        mem_we    = 1'b1;
        mem_waddr = left_node | NODE_W'(1);
        mem_wdata = {1'b1, push_val_r};
        state_nxt = S_EVAL;
      end
      S_DESC: begin
        if (k_r == '0) begin
          state_nxt = S_RDOUT;
        end
      end
      S_RDOUT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_wr_en) begin
      state_nxt = S_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      len_m1_r   <= IDX_W'(MAX_LENGTH - 1);
      clr_addr_r <= '0;
      sp_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        len_m1_r   <= IDX_W'(cfg_len - LEN_W'(1));
        clr_addr_r <= '0;
      end else if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + NODE_W'(1);
      end
      // walk stack pointer: seed with root, pop in eval, push two children
      if (state_r == S_IDLE && !q_stat.empty && !head_cmd.is_read) begin
        sp_r <= SP_W'(1);
      end else if (state_r == S_EVAL && sp_r != '0) begin
        sp_r <= sp_r - SP_W'(1);
      end else if ((state_r == S_RDWAIT && !rd_data_r[VALUE_W]) || state_r == S_WRIGHT) begin
        sp_r <= sp_r + SP_W'(2);
      end
    end
  end

  // walk stack and working registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && !q_stat.empty) begin
      cmd_r      <= head_cmd;
      stack_r[0] <= '{node: NODE_W'(1), lo: '0, hi: len_m1_r};
      dlo_r      <= '0;
      dhi_r      <= len_m1_r;
      k_r        <= head_cmd.msb_pos;
      used_r     <= head_cmd.node_ok;
    end
    if (state_r == S_EVAL && sp_r != '0) begin
      cur_r <= top;
      mid_r <= top_mid;
    end
    if (state_r == S_RDWAIT) begin
      push_val_r <= rd_data_r[VALUE_W-1:0];
    end
    if ((state_r == S_RDWAIT && !rd_data_r[VALUE_W]) || state_r == S_WRIGHT) begin
      // right child goes below left so left is visited first
      stack_r[sp_r] <= '{node: left_node | NODE_W'(1),
                         lo: IDX_W'(mid_r + IDX_W'(1)), hi: cur_r.hi};
      stack_r[sp_r + SP_W'(1)] <= '{node: left_node, lo: cur_r.lo, hi: mid_r};
    end
    // read descent: one tree level per cycle
    if (state_r == S_DESC && k_r != '0) begin
      if (dlo_r == dhi_r) begin
        used_r <= 1'b0;
      end
      if (cmd_r.node[k_r - POS_W'(1)]) begin
        dlo_r <= IDX_W'(d_mid + IDX_W'(1));
      end else begin
        dhi_r <= d_mid;
      end
      k_r <= k_r - POS_W'(1);
    end
  end

  // node value and mark memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RDOUT && (!out_valid_r || out_chan.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RDOUT && (!out_valid_r || out_chan.ready)) begin
      out_value_r <= used_r ? rd_data_r[VALUE_W-1:0] : '0;
      out_pend_r  <= used_r ? rd_data_r[VALUE_W] : 1'b0;
      out_lo_r    <= used_r ? dlo_r : '0;
      out_hi_r    <= used_r ? dhi_r : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.node_value   = out_value_r;
  assign out_chan.node_pending = out_pend_r;
  assign out_chan.node_low     = out_lo_r;
  assign out_chan.node_high    = out_hi_r;

endmodule

@@ rtl/lazy_range_assign_segment_tree_top.sv @@
// ----------------------------------------------------------------------------
// lazy_range_assign_segment_tree_top
// Segment tree over up to 1024 elements with lazy range assignment.
// ----------------------------------------------------------------------------
// After reset and after every write of the length register the block sweeps
// its node memory clear, one node a cycle, and takes no request meanwhile.
// An assign request walks the tree depth first from the root through a
// single-port node memory: a skipped or fully covered node is handled in
// S_EVAL alone, a partly covered one is read in S_EVAL and checked in
// S_RDWAIT, and a pending value found there is pushed down in S_WLEFT and
// S_WRIGHT; about 4*log2(length) nodes are visited. A read request fetches
// its node in S_IDLE, narrows its span one tree level a cycle in S_DESC and
// registers the result in S_RDOUT. A two-entry queue lets requests arrive
// while the engine is busy; the front drops an empty-range assign unanswered.
module lazy_range_assign_segment_tree_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lrast_pkg::LEN_W-1:0] cfg_wr_data,
  lrast_in_if.sink                    in_chan,
  lrast_out_if.source                 out_chan
);
  import lrast_pkg::*;

  logic    push, pop, clearing;
  cmd_t    push_cmd, head_cmd;
  q_stat_t q_stat;

  // request classification
  lrast_front u_front (
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .clearing (clearing),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decoupling queue
  lrast_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // walk engine
  lrast_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_cmd    (head_cmd),
    .q_stat      (q_stat),
    .pop         (pop),
    .clearing    (clearing),
    .out_chan    (out_chan)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives assign and read requests into the segment tree, mirrors the tree
// in a local array model and compares each node read against it or against a hand-read result.
// ----------------------------------------------------------------------------
module tb;
  import lrast_pkg::*;

  localparam int MAX_WAIT = 16;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      pending;
    logic [IDX_W-1:0]          low;
    logic [IDX_W-1:0]          high;
  } node_read_t;

  typedef struct {
    logic [0:0]                action;
    logic [IDX_W-1:0]          first;
    logic [IDX_W-1:0]          last;
    logic signed [VALUE_W-1:0] value;
    logic [NODE_W-1:0]         node;
    bit                        has_fixed;
    node_read_t                fixed;
  } request_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  lrast_in_if  in_chan ();
  lrast_out_if out_chan ();

  lazy_range_assign_segment_tree_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan.sink),
    .out_chan    (out_chan.source)
  );

  // mirror of the tree
  logic signed [VALUE_W-1:0] tree_val  [NODE_COUNT];
  bit                        tree_mark [NODE_COUNT];
  logic [IDX_W-1:0]          tree_lo   [NODE_COUNT];
  logic [IDX_W-1:0]          tree_hi   [NODE_COUNT];
  bit                        tree_used [NODE_COUNT];
  int unsigned               cur_length;

  node_read_t expected_reads[$];
  int  errors;
  bit  hold_off;
  int  sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("** lazy_range_assign_segment_tree_top: FAILED **");
    $finish;
  end

  function automatic void build_node(int n, int lo, int hi);
    int mid;
    if (n >= NODE_COUNT) return;
    tree_lo[n] = IDX_W'(lo);
    tree_hi[n] = IDX_W'(hi);
    tree_used[n] = 1'b1;
    if (lo == hi) return;
    mid = lo + (hi - lo) / 2;
    build_node(2 * n, lo, mid);
    build_node(2 * n + 1, mid + 1, hi);
  endfunction

  function automatic void rebuild_tree(int unsigned wr);
    int unsigned len;
    len = wr;
    if (len == 0) len = 1;
    if (len > MAX_LENGTH) len = MAX_LENGTH;
    cur_length = len;
    for (int i = 0; i < NODE_COUNT; i++) begin
      tree_val[i] = '0;
      tree_mark[i] = 1'b0;
      tree_lo[i] = '0;
      tree_hi[i] = '0;
      tree_used[i] = 1'b0;
    end
    build_node(1, 0, len - 1);
  endfunction

  // lazy assign walk, depth first, left child first
  function automatic void assign_span(int first, int last, logic signed [VALUE_W-1:0] v);
    int stack[$];
    int n;
    stack.insert(stack.size(), 1);
    while (stack.size() > 0) begin
      n = stack.pop_back();
      if (n >= NODE_COUNT || !tree_used[n]) continue;
      if (last < tree_lo[n] || tree_hi[n] < first) continue;
      if (tree_lo[n] >= first && tree_hi[n] <= last) begin
        tree_mark[n] = 1'b1;
        tree_val[n] = v;
        continue;
      end
      if (tree_mark[n] && 2 * n + 1 < NODE_COUNT) begin
        tree_val[2 * n] = tree_val[n];
        tree_val[2 * n + 1] = tree_val[n];
        tree_mark[n] = 1'b0;
        tree_mark[2 * n] = 1'b1;
        tree_mark[2 * n + 1] = 1'b1;
      end
      stack.insert(stack.size(), 2 * n + 1);
      stack.insert(stack.size(), 2 * n);
    end
  endfunction

  function automatic node_read_t read_node(int n);
    node_read_t r;
    r = '0;
    if (n < NODE_COUNT && tree_used[n]) begin
      r.value = tree_val[n];
      r.pending = tree_mark[n];
      r.low = tree_lo[n];
      r.high = tree_hi[n];
    end
    return r;
  endfunction

  // send one request, predict, and queue the expected read
  task automatic send_request(request_t rq);
    node_read_t r;
    int n_wait;
    n_wait = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, MAX_WAIT));
    if (n_wait > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n_wait) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= rq.action;
    in_chan.range_start <= rq.first;
    in_chan.range_end <= rq.last;
    in_chan.assign_value <= rq.value;
    in_chan.node_index <= rq.node;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (rq.action == ACT_ASSIGN) begin
      assign_span(rq.first, rq.last, rq.value);
    end else begin
      r = read_node(rq.node);
      expected_reads.insert(expected_reads.size(), rq.has_fixed ? rq.fixed : r);
    end
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    while (expected_reads.size() > 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_length(int unsigned len);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= LEN_W'(len);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rebuild_tree(len);
  endtask

  function automatic request_t make_assign(int f, int l, logic signed [VALUE_W-1:0] v);
    request_t rq;
    rq = '{default: '0};
    rq.action = ACT_ASSIGN;
    rq.first = IDX_W'(f);
    rq.last = IDX_W'(l);
    rq.value = v;
    rq.node = NODE_W'($urandom);
    return rq;
  endfunction

  function automatic request_t make_read(int n);
    request_t rq;
    rq = '{default: '0};
    rq.action = ACT_READ;
    rq.node = NODE_W'(n);
    rq.first = IDX_W'($urandom);
    rq.last = IDX_W'($urandom);
    rq.value = $urandom;
    return rq;
  endfunction

  function automatic request_t random_request();
    int f, l;
    if ($urandom_range(0, 1)) begin
      f = $urandom_range(0, cur_length - 1);
      l = $urandom_range(f, cur_length - 1);
      if ($urandom_range(0, 9) == 0) begin
        f = $urandom_range(0, 1023);
        l = $urandom_range(0, 1023);
      end
      return make_assign(f, l, $urandom);
    end
    if ($urandom_range(0, 9) == 0) return make_read($urandom_range(0, 8191));
    return make_read($urandom_range(1, 4 * cur_length - 1));
  endfunction

  // result checker with random stalls
  initial begin
    node_read_t exp_r;
    node_read_t got;
    int ready_wait;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_chan.ready <= 1'b0;
      else begin
        ready_wait = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, MAX_WAIT));
        if (ready_wait > 0) begin
          out_chan.ready <= 1'b0;
          repeat (ready_wait) @(negedge clk);
        end
        out_chan.ready <= !hold_off;
      end
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.node_value, out_chan.node_pending, out_chan.node_low,
                out_chan.node_high};
        if (expected_reads.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          exp_r = expected_reads.pop_front();
          if (got.value !== exp_r.value) begin
            errors++;
            $display("%0t: value exp %h got %h", $time, exp_r.value, got.value);
          end
          if (got.pending !== exp_r.pending) begin
            errors++;
            $display("%0t: pending exp %b got %b", $time, exp_r.pending, got.pending);
          end
          if (got.low !== exp_r.low) begin
            errors++;
            $display("%0t: low exp %0d got %0d", $time, exp_r.low, got.low);
          end
          if (got.high !== exp_r.high) begin
            errors++;
            $display("%0t: high exp %0d got %0d", $time, exp_r.high, got.high);
          end
        end
      end
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    hold_off = 1'b0;
    wait (sent == 400);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // stimulus
  initial begin
    request_t dir_tab[$];
    request_t rq;
    errors = 0;
    sent = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_chan.valid = 1'b0;
    in_chan.action = ACT_ASSIGN;
    in_chan.range_start = '0;
    in_chan.range_end = '0;
    in_chan.assign_value = '0;
    in_chan.node_index = '0;
    rebuild_tree(MAX_LENGTH);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: fixed rows carry a hand-read result
    rq = make_read(1); rq.has_fixed = 1;
    rq.fixed = '{32'sd0, 1'b0, 10'd0, 10'd1023}; dir_tab = {dir_tab, rq};
    rq = make_read(0); rq.has_fixed = 1; rq.fixed = '0; dir_tab = {dir_tab, rq};
    rq = make_read(8191); rq.has_fixed = 1; rq.fixed = '0; dir_tab = {dir_tab, rq};
    rq = make_read(4096); rq.has_fixed = 1; rq.fixed = '0; dir_tab = {dir_tab, rq};
    dir_tab = {dir_tab, make_assign(0, 1023, 32'sh7fffffff)};
    rq = make_read(1); rq.has_fixed = 1;
    rq.fixed = '{32'sh7fffffff, 1'b1, 10'd0, 10'd1023};
    dir_tab = {dir_tab, rq};
    dir_tab = {dir_tab, make_assign(5, 5, 32'sh80000000)};
    dir_tab = {dir_tab, make_read(2)};
    dir_tab = {dir_tab, make_read(3)};
    dir_tab = {dir_tab, make_assign(10, 3, 32'sh12345678)};
    dir_tab = {dir_tab, make_assign(1023, 1023, -1)};
    dir_tab = {dir_tab, make_read(2047)};
    dir_tab = {dir_tab, make_assign(300, 700, 32'sh55aa55aa)};
    dir_tab = {dir_tab, make_read(4)};
    dir_tab = {dir_tab, make_read(5)};
    dir_tab = {dir_tab, make_read(1024)};
    foreach (dir_tab[i]) send_request(dir_tab[i]);

    // length extremes and special writes
    write_length(0);
    dir_tab = {};
    rq = make_read(1); rq.has_fixed = 1;
    rq.fixed = '{32'sd0, 1'b0, 10'd0, 10'd0}; dir_tab = {dir_tab, rq};
    dir_tab = {dir_tab, make_assign(0, 1023, 32'sh0000ffff)};
    dir_tab = {dir_tab, make_read(1)};
    rq = make_read(2); rq.has_fixed = 1; rq.fixed = '0; dir_tab = {dir_tab, rq};
    foreach (dir_tab[i]) send_request(dir_tab[i]);
    write_length(2047);
    send_request(make_read(1));
    write_length(2);
    for (int i = 0; i < 20; i++) send_request(random_request());
    write_length(1024);

    // random phases across several lengths
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 160; i++) send_request(random_request());
      case (ph)
        0: write_length(1);
        1: write_length($urandom_range(3, 100));
        2: write_length(1023);
        3: write_length($urandom_range(0, 2047));
        default: write_length($urandom_range(1, 1024));
      endcase
    end

    wait_drain();
    if (errors == 0) begin
      $display("** lazy_range_assign_segment_tree_top: PASSED **");
    end else begin
      $display("** lazy_range_assign_segment_tree_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ lazy_range_assign_segment_tree_top.f @@
rtl/lrast_pkg.sv
rtl/lrast_ifs.sv
rtl/lrast_queue.sv
rtl/lrast_front.sv
rtl/lrast_back.sv
rtl/lazy_range_assign_segment_tree_top.sv
dv/tb.sv
